/* rtl/core/tem_pkg.sv */
// Package for the text extent measurement block: item kinds, character codes,
// register indexes and the structs passed between the modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tem_pkg;

   // Item kinds carried in the request tuser field.
   typedef enum logic [1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_CHAR = 2'd1,
      FUNC_END  = 2'd2
   } func_type;

   // Character codes with special meaning.
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_RETURN  = 8'd13;
   localparam logic [7:0] CODE_SPACE   = 8'd32;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_FONT_VALID  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MONOSPACE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPACE_WIDTH = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_LIMIT = 3'd5;

   // Register reset values.
   localparam logic [7:0] CELL_WIDTH_RESET  = 8'd1;
   localparam logic [7:0] CELL_HEIGHT_RESET = 8'd1;
   localparam logic [7:0] SPACE_WIDTH_RESET = 8'd4;

   localparam logic [15:0] MAX16 = 16'hFFFF;

   typedef struct packed {
      logic        font_valid;
      logic        monospace;
      logic [7:0]  cell_width;
      logic [7:0]  cell_height;
      logic [7:0]  space_width;
      logic [15:0] width_limit;
   } cfg_type;

   // One item as seen by the measurement engine, with its table entry.
   typedef struct packed {
      func_type    func;
      logic [7:0]  char_code;
      logic        in_range;
      logic [7:0]  table_adv;
   } item_type;

   typedef struct packed {
      logic [15:0] text_width;
      logic [15:0] text_height;
   } result_type;

   // Saturating 16-bit add.
   function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? MAX16 : s[15:0];
   endfunction

endpackage : tem_pkg

`default_nettype wire

/* rtl/core/tem_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tem_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : tem_ram

`default_nettype wire

/* rtl/core/tem_engine.sv */
// Measurement engine: cursor, added height and widest line registers, updated
// once per item, and the extent produced by an end item. Uses tem_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tem_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire tem_pkg::item_type   item,
   input  wire tem_pkg::cfg_type    cfg,
   output tem_pkg::result_type      result
);
   import tem_pkg::*;

   logic [15:0] cursor_ff, cursor_in;
   logic [15:0] extra_ff, extra_in;
   logic [15:0] max_ff, max_in;

   logic [7:0]  advance;
   logic [16:0] sum;
   logic [15:0] line_max;
   logic [15:0] extra_plus;
   logic        wrap;

   always_comb begin
      if (cfg.monospace) begin
         advance = cfg.cell_width;
      end else if (item.char_code == CODE_SPACE) begin
         advance = cfg.space_width;
      end else if (item.in_range) begin
         advance = item.table_adv;
      end else begin
         advance = 8'd0;
      end

      sum        = {1'b0, cursor_ff} + {9'd0, advance};
      line_max   = (cursor_ff > max_ff) ? cursor_ff : max_ff;
      extra_plus = sat_add16(extra_ff, {8'd0, cfg.cell_height});
      wrap       = (cfg.width_limit != 16'd0) && (cursor_ff != 16'd0)
                   && (sum > {1'b0, cfg.width_limit});

      cursor_in = cursor_ff;
      extra_in  = extra_ff;
      max_in    = max_ff;

      result.text_width  = cfg.font_valid ? line_max : 16'd0;
      result.text_height = cfg.font_valid
                           ? sat_add16({8'd0, cfg.cell_height}, extra_ff) : 16'd0;

      case (item.func)
         FUNC_CHAR: begin
            if (item.char_code == CODE_NEWLINE) begin
               max_in    = line_max;
               cursor_in = 16'd0;
               extra_in  = extra_plus;
            end else if (item.char_code == CODE_RETURN) begin
               max_in    = line_max;
               cursor_in = 16'd0;
            end else if (wrap) begin
               // The character moves to a fresh line and starts it.
               max_in    = line_max;
               extra_in  = extra_plus;
               cursor_in = {8'd0, advance};
            end else begin
               cursor_in = sum[16] ? MAX16 : sum[15:0];
            end
         end
         FUNC_END: begin
            cursor_in = 16'd0;
            extra_in  = 16'd0;
            max_in    = 16'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= 16'd0;
         extra_ff  <= 16'd0;
         max_ff    <= 16'd0;
      end else if (step) begin
         cursor_ff <= cursor_in;
         extra_ff  <= extra_in;
         max_ff    <= max_in;
      end
   end

endmodule : tem_engine

`default_nettype wire

/* rtl/core/text_extent_measure_unit.sv */
// Top level of the text extent measurement block: configuration registers,
// input stage with the glyph advance RAM, engine and result register.
// Depends on tem_pkg, tem_ram and tem_engine.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake           Payload
// req       in   req_tvalid/tready   tdata: char_code, glyph_width; tuser: func
// rsp       out  rsp_tvalid/tready   tdata: text_width, text_height
// csr       in   csr_we              csr_index, csr_wdata
//
// One item is accepted per cycle while the request side does not stall. An
// item waits in the input stage, where the glyph advance RAM read completes,
// and the engine and, for an end item, the result register update as it leaves.
// Reset clears the configuration to its defaults and the text state; the glyph
// table is not cleared. The request side stalls only while an end item in the
// input stage waits on a result that has not yet been taken.

module text_extent_measure_unit #(
   parameter int unsigned GLYPH_COUNT = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request channel.
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [15:0]                        req_tdata,  // [7:0] char_code, [15:8] glyph_width
   input  wire logic [1:0]                         req_tuser,  // [1:0] func
   // Response channel.
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [31:0]                        rsp_tdata,  // [15:0] text_width, [31:16] text_height
   // Configuration writes.
   input  wire logic                               csr_we,
   input  wire logic [tem_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [tem_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tem_pkg::*;

   localparam int unsigned ADDR_W = $clog2(GLYPH_COUNT);

   // Configuration registers.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.font_valid  <= 1'b0;
         cfg_ff.monospace   <= 1'b0;
         cfg_ff.cell_width  <= CELL_WIDTH_RESET;
         cfg_ff.cell_height <= CELL_HEIGHT_RESET;
         cfg_ff.space_width <= SPACE_WIDTH_RESET;
         cfg_ff.width_limit <= 16'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FONT_VALID:  cfg_ff.font_valid  <= csr_wdata[0];
            CSR_MONOSPACE:   cfg_ff.monospace   <= csr_wdata[0];
            CSR_CELL_WIDTH:  cfg_ff.cell_width  <= csr_wdata[7:0];
            CSR_CELL_HEIGHT: cfg_ff.cell_height <= csr_wdata[7:0];
            CSR_SPACE_WIDTH: cfg_ff.space_width <= csr_wdata[7:0];
            CSR_WIDTH_LIMIT: cfg_ff.width_limit <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Request decode. Codes beyond the table are not stored and, unless monospace, advance by zero.
   logic     req_fire;
   func_type req_func;
   logic [7:0] req_code;
   logic       req_in_range;

   assign req_fire     = req_tvalid && req_tready;
   assign req_func     = func_type'(req_tuser);
   assign req_code     = req_tdata[7:0];
   assign req_in_range = ({1'b0, req_code} < 9'(GLYPH_COUNT));

   // The table is written and read at the transfer edge, so a load is seen by
   // a character taken in the very next cycle.
   logic [7:0] table_rd;

   tem_ram #(
      .WIDTH (8),
      .DEPTH (GLYPH_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (req_fire && (req_func == FUNC_LOAD) && req_in_range),
      .wr_addr (req_code[ADDR_W-1:0]),
      .wr_data (req_tdata[15:8]),
      .rd_en   (req_fire),
      .rd_addr (req_code[ADDR_W-1:0]),
      .rd_data (table_rd)
   );

   // Input stage.
   logic       s1_valid_ff;
   func_type   s1_func_ff;
   logic [7:0] s1_code_ff;
   logic       s1_in_range_ff;
   logic       s1_fire;

   // An end item may leave only when the result register is free or being
   // emptied in this cycle.
   assign s1_fire    = s1_valid_ff
                       && ((s1_func_ff != FUNC_END) || !rsp_tvalid || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff     <= req_func;
         s1_code_ff     <= req_code;
         s1_in_range_ff <= req_in_range;
      end
   end

   item_type   s1_item;
   result_type eng_result;

   assign s1_item = '{func:      s1_func_ff,
                      char_code: s1_code_ff,
                      in_range:  s1_in_range_ff,
                      table_adv: table_rd};

   tem_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (s1_fire),
      .item   (s1_item),
      .cfg    (cfg_ff),
      .result (eng_result)
   );

   // Result register.
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   logic       end_fire;

   assign end_fire = s1_fire && (s1_func_ff == FUNC_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (end_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (end_fire) begin
         rsp_data_ff <= eng_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.text_height, rsp_data_ff.text_width};

   // A new result only ever follows an end item leaving the input stage.
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(end_fire))
      else $error("result raised without an end item");

   // The request side stalls only behind an end item blocked by a waiting result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && (s1_func_ff == FUNC_END) && rsp_tvalid))
      else $error("request stalled without a blocked end item");

   // A blocked item stays in the input stage unchanged.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(s1_code_ff)
                                     && $stable(s1_func_ff)))
      else $error("input stage lost a blocked item");

endmodule : text_extent_measure_unit

`default_nettype wire
